@@ hdl/sync_framed_packet_validator_core_defines.svh @@
// Assertion macros for the packet validator checker.
// They use the checker's clock and reset ports and need no other file.
`ifndef SYNC_FRAMED_PACKET_VALIDATOR_CORE_DEFINES_SVH
`define SYNC_FRAMED_PACKET_VALIDATOR_CORE_DEFINES_SVH

// The property must hold in the same cycle as the condition.
`define SFPV_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// The property must hold in the cycle after the condition.
`define SFPV_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ hdl/sfpv_pkg.sv @@
// Shared constants for the framed packet validator.
// Used by the core and by its checker; depends on nothing.
package sfpv_pkg;

   localparam logic [7:0] HDR0 = 8'hA5;
   localparam logic [7:0] HDR1 = 8'h5A;

   localparam int PAYLOAD_LEN = 3;
   localparam int PKT_LEN     = PAYLOAD_LEN + 3;
   localparam int BEAT_W      = $clog2(PKT_LEN);

   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(PKT_LEN - 1);

endpackage

@@ hdl/sync_framed_packet_validator_core.sv @@
// Framed packet validator core: header hunt, payload capture and checksum test.
// Depends on sfpv_pkg for the header bytes and packet lengths.
//
// Usage:
// The req channel carries one received byte per beat in req_tdata. The block
// hunts for the header A5 5A, takes three payload bytes and a checksum byte.
// When the checksum equals the 8-bit sum of the payload, the rsp channel
// delivers six beats: A5, 5A, the three payload bytes and the checksum, with
// rsp_tlast high on the sixth. A packet with a bad checksum gives no beats.
// Output: the first response beat is valid in the cycle after the checksum
// beat is accepted; later beats go out one per cycle while rsp_tready is high.
// Throughput: one request beat per cycle but for the stall below. A finished
// packet has its own output buffer, so the next one is parsed while it drains.
// Stall: req_tready drops only when a checksum byte is due while the output
// buffer still holds beats that the receiver has not taken.
// Reset: synchronous, active high; the parser returns to the header hunt and
// the output buffer is emptied.
module sync_framed_packet_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] tx_byte
   output logic       rsp_tlast    // last_byte
);

   localparam logic [1:0] PH_HUNT0 = 2'd0;
   localparam logic [1:0] PH_HUNT1 = 2'd1;
   localparam logic [1:0] PH_BODY  = 2'd2;

   localparam logic [1:0] CNT_FULL = 2'(sfpv_pkg::PAYLOAD_LEN);

   logic [1:0] phase_ff, phase_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] store_ff [0:sfpv_pkg::PAYLOAD_LEN-1];
   logic [7:0] pkt_ff [0:sfpv_pkg::PAYLOAD_LEN-1];
   logic [7:0] ck_ff;
   logic       busy_ff, busy_in;
   logic [sfpv_pkg::BEAT_W-1:0] beat_ff, beat_in;

   logic       accept;
   logic       out_take;
   logic       emit_done;
   logic       check_now;
   logic       good;
   logic [7:0] sum;

   assign accept    = req_tvalid && req_tready;
   assign out_take  = busy_ff && rsp_tready;
   assign emit_done = out_take && (beat_ff == sfpv_pkg::LAST_BEAT);
   assign check_now = (phase_ff == PH_BODY) && (count_ff == CNT_FULL);
   assign req_tready = !check_now || !busy_ff || emit_done;
   assign sum  = store_ff[0] + store_ff[1] + store_ff[2];
   assign good = accept && check_now && (sum == req_tdata);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      if (accept) begin
         case (phase_ff)
            PH_HUNT1: begin
               if (req_tdata == sfpv_pkg::HDR1) begin
                  count_in = 2'd0;
                  phase_in = PH_BODY;
               end else if (req_tdata == sfpv_pkg::HDR0) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_BODY: begin
               if (count_ff < CNT_FULL) begin
                  count_in = count_ff + 2'd1;
               end else begin
                  count_in = 2'd0;
                  phase_in = PH_HUNT0;
               end
            end
            default: begin
               phase_in = (req_tdata == sfpv_pkg::HDR0) ? PH_HUNT1 : PH_HUNT0;
            end
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (good) begin
         busy_in = 1'b1;
         beat_in = '0;
      end else if (emit_done) begin
         busy_in = 1'b0;
         beat_in = '0;
      end else if (out_take) begin
         beat_in = beat_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         count_ff <= 2'd0;
         busy_ff  <= 1'b0;
         beat_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         busy_ff  <= busy_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PH_BODY) && (count_ff < CNT_FULL)) begin
         store_ff[count_ff] <= req_tdata;
      end
      if (good) begin
         for (int i = 0; i < sfpv_pkg::PAYLOAD_LEN; i++) begin
            pkt_ff[i] <= store_ff[i];
         end
         ck_ff <= req_tdata;
      end
   end

   always_comb begin
      case (beat_ff)
         3'd0:    rsp_tdata = sfpv_pkg::HDR0;
         3'd1:    rsp_tdata = sfpv_pkg::HDR1;
         3'd2:    rsp_tdata = pkt_ff[0];
         3'd3:    rsp_tdata = pkt_ff[1];
         3'd4:    rsp_tdata = pkt_ff[2];
         default: rsp_tdata = ck_ff;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (beat_ff == sfpv_pkg::LAST_BEAT);

endmodule

@@ hdl/sfpv_checker.sv @@
// Port-level checker for the framed packet validator core, bound to the top.
// Depends on sfpv_pkg and on the assertion macros in the defines header.
`include "sync_framed_packet_validator_core_defines.svh"

module sfpv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   logic [sfpv_pkg::BEAT_W-1:0] beat_count_ff;
   logic                        rsp_take;
   logic                        rsp_stall;
   logic                        req_take;
   logic                        first_beat;
   logic                        second_beat;
   logic                        last_due;

   assign rsp_take    = rsp_tvalid && rsp_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign req_take    = req_tvalid && req_tready;
   assign first_beat  = rsp_take && (beat_count_ff == '0);
   assign second_beat = rsp_take && (beat_count_ff == sfpv_pkg::BEAT_W'(1));
   assign last_due    = (beat_count_ff == sfpv_pkg::LAST_BEAT);

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_count_ff <= '0;
      end else if (rsp_take) begin
         beat_count_ff <= rsp_tlast ? '0 : beat_count_ff + 1'b1;
      end
   end

   `SFPV_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable({rsp_tdata, rsp_tlast}), "held beat changed")
   `SFPV_ASSERT_NOW(a_first_hdr, first_beat, rsp_tdata == sfpv_pkg::HDR0, "first packet byte is not A5")
   `SFPV_ASSERT_NOW(a_second_hdr, second_beat, rsp_tdata == sfpv_pkg::HDR1, "second packet byte is not 5A")
   `SFPV_ASSERT_NOW(a_last_pos, rsp_take, rsp_tlast == last_due, "last marker not on the sixth beat")
   `SFPV_ASSERT_NEXT(a_rsp_source, !rsp_tvalid && !req_take, !rsp_tvalid, "beat with no request beat")

endmodule

bind sync_framed_packet_validator_core sfpv_checker u_sfpv_checker (.*);
